// File: hdl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, constants and haptic codes of the hold-to-shutdown controller.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam logic [7:0] LedMax = 8'd255;

  localparam logic [2:0] HAP_NONE   = 3'd0;
  localparam logic [2:0] HAP_STRONG = 3'd1;
  localparam logic [2:0] HAP_MEDIUM = 3'd2;
  localparam logic [2:0] HAP_BUZZ   = 3'd3;
  localparam logic [2:0] HAP_TRIPLE = 3'd4;

  localparam logic [2:0] REG_COMMIT  = 3'd0;
  localparam logic [2:0] REG_WARN    = 3'd1;
  localparam logic [2:0] REG_WARMUP  = 3'd2;
  localparam logic [2:0] REG_FIRE    = 3'd3;
  localparam logic [2:0] REG_CLICK   = 3'd4;
  localparam logic [2:0] REG_RELEASE = 3'd5;
  localparam logic [2:0] REG_UPTIME  = 3'd6;

  localparam int DivSteps = 40;
  localparam logic [5:0] DivLast = 6'(DivSteps - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the item
    logic eval;      // run the tick logic and update state
    logic div_step;  // one restoring-division step
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
  } stat_t;

  function automatic logic [2:0] hap_rank(input logic [2:0] code);
    unique case (code)
      HAP_BUZZ:   hap_rank = 3'd4;
      HAP_TRIPLE: hap_rank = 3'd3;
      HAP_STRONG: hap_rank = 3'd2;
      HAP_MEDIUM: hap_rank = 3'd1;
      default:    hap_rank = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] hap_merge(input logic [2:0] cur, input logic [2:0] code);
    hap_merge = (hap_rank(code) > hap_rank(cur)) ? code : cur;
  endfunction

endpackage

// File: hdl/hts_ctrl.sv
// ----------------------------------------------------------------------------
// hts_ctrl
// Sequencer: evaluate a tick, run the ramp divider if needed, deliver result.
// ----------------------------------------------------------------------------
module hts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  hts_pkg::stat_t  stat_i,
  output hts_pkg::ctrl_t  ctrl_o
);

  hts_pkg::state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hts_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl_o      = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      hts_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = hts_pkg::ST_EVAL;
        end
      end
      hts_pkg::ST_EVAL: begin
        ctrl_o.eval = 1'b1;
        cnt_d = '0;
        state_d = stat_i.need_div ? hts_pkg::ST_DIV : hts_pkg::ST_OUT;
      end
      hts_pkg::ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == hts_pkg::DivLast) begin
          state_d = hts_pkg::ST_OUT;
        end
      end
      hts_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = hts_pkg::ST_IDLE;
      end
      default: state_d = hts_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hdl/hts_dp.sv
// ----------------------------------------------------------------------------
// hts_dp
// Press state, uptime cap, haptic merge and a serial ramp divider.
// ----------------------------------------------------------------------------
module hts_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hts_pkg::ctrl_t  ctrl_i,
  output hts_pkg::stat_t  stat_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  logic [31:0]     time_ms_i,
  input  logic            button_pressed_i,
  input  logic            recording_busy_i,
  input  logic            battery_test_busy_i,
  input  logic            restart_request_i,
  output logic            led_write_o,
  output logic [7:0]      led_level_o,
  output logic [2:0]      haptic_code_o,
  output logic            ship_request_o,
  output logic            hold_committed_o
);

  logic [15:0] commit_q, warn_q, warmup_q, fire_q, click_q, release_q;
  logic [31:0] uptime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      commit_q  <= 16'd1000;
      warn_q    <= 16'd2000;
      warmup_q  <= 16'd3700;
      fire_q    <= 16'd4000;
      click_q   <= 16'd500;
      release_q <= 16'd80;
      uptime_q  <= 32'd900000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hts_pkg::REG_COMMIT:  commit_q  <= cfg_data_i[15:0];
        hts_pkg::REG_WARN:    warn_q    <= cfg_data_i[15:0];
        hts_pkg::REG_WARMUP:  warmup_q  <= cfg_data_i[15:0];
        hts_pkg::REG_FIRE:    fire_q    <= cfg_data_i[15:0];
        hts_pkg::REG_CLICK:   click_q   <= cfg_data_i[15:0];
        hts_pkg::REG_RELEASE: release_q <= cfg_data_i[15:0];
        hts_pkg::REG_UPTIME:  uptime_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured item
  logic [31:0] now_q;
  logic low_q, busy_q, rreq_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      now_q  <= time_ms_i;
      low_q  <= button_pressed_i;
      busy_q <= recording_busy_i | battery_test_busy_i;
      rreq_q <= restart_request_i;
    end
  end

  // press state
  logic holding_q, warn_begun_q, warm_done_q, rel_timing_q;
  logic committed_q, ship_latched_q, restart_q;
  logic [31:0] press_q, click_t_q, rel_start_q, deadline_q;
  logic holding_d, warn_begun_d, warm_done_d, rel_timing_d;
  logic committed_d, ship_latched_d, restart_d;
  logic [31:0] press_d, click_t_d, rel_start_d, deadline_d;

  // tick results
  logic       lw_d, lw_q;
  logic [7:0] lvl_d, lvl_q;
  logic       ramp_d, ramp_q;   // level comes from the divider
  logic [2:0] hap_d, hap_q;
  logic       ship_d, ship_q;
  logic [31:0] held_d;

  always_comb begin
    logic [31:0] held;
    logic        fire_now;
    holding_d      = holding_q;
    warn_begun_d   = warn_begun_q;
    warm_done_d    = warm_done_q;
    rel_timing_d   = rel_timing_q;
    committed_d    = committed_q;
    ship_latched_d = ship_latched_q;
    restart_d      = restart_q | rreq_q;
    press_d        = press_q;
    click_t_d      = click_t_q;
    rel_start_d    = rel_start_q;
    deadline_d     = deadline_q;
    lw_d   = 1'b0;
    lvl_d  = '0;
    ramp_d = 1'b0;
    hap_d  = hts_pkg::HAP_NONE;
    ship_d = 1'b0;
    held   = '0;
    fire_now = 1'b0;

    if (busy_q) deadline_d = now_q + uptime_q;
    if (!busy_q && now_q >= deadline_q) begin
      lw_d = 1'b1;
      lvl_d = hts_pkg::LedMax;
      fire_now = 1'b1;
      committed_d = 1'b0;
      deadline_d = now_q + uptime_q;
    end
    // fire from the cap is applied right here
    if (fire_now) begin
      hap_d = hts_pkg::hap_merge(hap_d, hts_pkg::HAP_BUZZ);
      if (!ship_latched_d) begin
        ship_latched_d = 1'b1;
        ship_d = 1'b1;
        lw_d = 1'b1;
        lvl_d = hts_pkg::LedMax;
      end
    end
    fire_now = 1'b0;

    if (restart_d && holding_q && low_q) begin
      press_d = now_q;
      click_t_d = '0;
      warn_begun_d = 1'b0;
      restart_d = 1'b0;
    end else if (restart_d && !low_q) begin
      restart_d = 1'b0;
    end

    if (low_q && !holding_q) begin
      holding_d = 1'b1;
      press_d = now_q;
      click_t_d = '0;
      warn_begun_d = 1'b0;
      warm_done_d = 1'b0;
      rel_timing_d = 1'b0;
      lw_d = 1'b1;
      lvl_d = '0;
      ramp_d = 1'b0;
    end else if (!low_q && holding_q) begin
      if (!rel_timing_q) begin
        rel_timing_d = 1'b1;
        rel_start_d = now_q;
      end
      held = now_q - press_d;
      if ((now_q - rel_start_d) < {16'd0, release_q}) begin
        lw_d = 1'b1;
        ramp_d = 1'b1;
        if (held >= {16'd0, fire_q}) begin
          fire_now = 1'b1;
          committed_d = 1'b0;
          holding_d = 1'b0;
          warn_begun_d = 1'b0;
          rel_timing_d = 1'b0;
        end
      end else begin
        holding_d = 1'b0;
        rel_timing_d = 1'b0;
        committed_d = 1'b0;
        if (held >= {16'd0, fire_q}) begin
          fire_now = 1'b1;
          warn_begun_d = 1'b0;
          warm_done_d = 1'b0;
        end else if (held >= {16'd0, warn_q}) begin
          hap_d = hts_pkg::hap_merge(hap_d, hts_pkg::HAP_MEDIUM);
          warn_begun_d = 1'b0;
          warm_done_d = 1'b0;
        end
      end
    end else if (low_q && holding_q) begin
      rel_timing_d = 1'b0;
      held = now_q - press_d;
      if (!committed_d && held >= {16'd0, commit_q}) committed_d = 1'b1;
      if (committed_d) begin
        lw_d = 1'b1;
        ramp_d = 1'b1;
      end
      if (held >= {16'd0, warn_q} && held < {16'd0, warmup_q}) begin
        if (!warn_begun_d) begin
          warn_begun_d = 1'b1;
          hap_d = hts_pkg::hap_merge(hap_d, hts_pkg::HAP_STRONG);
          click_t_d = now_q;
        end else if ((now_q - click_t_d) >= {16'd0, click_q}) begin
          click_t_d = now_q;
          hap_d = hts_pkg::hap_merge(hap_d, hts_pkg::HAP_STRONG);
        end
      end
      if (held >= {16'd0, warmup_q} && held < {16'd0, fire_q} && !warm_done_d) begin
        warm_done_d = 1'b1;
        hap_d = hts_pkg::hap_merge(hap_d, hts_pkg::HAP_TRIPLE);
      end
      if (held >= {16'd0, fire_q}) begin
        fire_now = 1'b1;
        committed_d = 1'b0;
        holding_d = 1'b0;
        warn_begun_d = 1'b0;
        warm_done_d = 1'b0;
      end
    end

    if (fire_now) begin
      hap_d = hts_pkg::hap_merge(hap_d, hts_pkg::HAP_BUZZ);
      if (!ship_latched_d) begin
        ship_latched_d = 1'b1;
        ship_d = 1'b1;
        lw_d = 1'b1;
        lvl_d = hts_pkg::LedMax;
        ramp_d = 1'b0;
      end
    end
    // a ramp over a zero divisor reads as full scale
    if (ramp_d && fire_q == 16'd0) begin
      lvl_d = hts_pkg::LedMax;
      ramp_d = 1'b0;
    end
    held_d = held;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q      <= 1'b0;
      warn_begun_q   <= 1'b0;
      warm_done_q    <= 1'b0;
      rel_timing_q   <= 1'b0;
      committed_q    <= 1'b0;
      ship_latched_q <= 1'b0;
      restart_q      <= 1'b0;
      press_q        <= '0;
      click_t_q      <= '0;
      rel_start_q    <= '0;
      deadline_q     <= 32'd900000;
    end else if (ctrl_i.eval) begin
      holding_q      <= holding_d;
      warn_begun_q   <= warn_begun_d;
      warm_done_q    <= warm_done_d;
      rel_timing_q   <= rel_timing_d;
      committed_q    <= committed_d;
      ship_latched_q <= ship_latched_d;
      restart_q      <= restart_d;
      press_q        <= press_d;
      click_t_q      <= click_t_d;
      rel_start_q    <= rel_start_d;
      deadline_q     <= deadline_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      lw_q   <= lw_d;
      lvl_q  <= lvl_d;
      ramp_q <= ramp_d;
      hap_q  <= hap_d;
      ship_q <= ship_d;
    end
  end

  assign stat_o.need_div = ramp_d;

  // restoring divider: (held * 255) / fire_ms, 40-bit dividend, one bit a step
  logic [39:0] quo_q;
  logic [16:0] rem_q;
  logic [16:0] rem_sh;

  assign rem_sh = {rem_q[15:0], quo_q[39]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      quo_q <= {held_d, 8'd0} - {8'd0, held_d};
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      if (rem_sh >= {1'b0, fire_q}) begin
        rem_q <= rem_sh - {1'b0, fire_q};
        quo_q <= {quo_q[38:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[38:0], 1'b0};
      end
    end
  end

  logic [7:0] ramp_lvl;
  assign ramp_lvl = (quo_q > {32'd0, hts_pkg::LedMax}) ? hts_pkg::LedMax : quo_q[7:0];

  always_comb begin
    led_write_o      = lw_q;
    led_level_o      = !lw_q ? 8'd0 : (ramp_q ? ramp_lvl : lvl_q);
    haptic_code_o    = hap_q;
    ship_request_o   = ship_q;
    hold_committed_o = committed_q;
  end

endmodule

// File: hdl/hold_to_shutdown_controller.sv
// ----------------------------------------------------------------------------
// hold_to_shutdown_controller
// Long-press power button controller with LED ramp, haptics and ship request.
// ----------------------------------------------------------------------------
// Sequence: capture, evaluate, then the 40-step ramp divider when an LED ramp
// is needed, then output; the output state holds while out_stall_i is high.
// A new item is accepted only after the previous result has been delivered.
// Reset: asynchronous active low; sequencer, configuration and press-state registers take defaults.
module hold_to_shutdown_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] time_ms_i,
  input  logic        button_pressed_i,
  input  logic        recording_busy_i,
  input  logic        battery_test_busy_i,
  input  logic        restart_request_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        led_write_o,
  output logic [7:0]  led_level_o,
  output logic [2:0]  haptic_code_o,
  output logic        ship_request_o,
  output logic        hold_committed_o
);

  hts_pkg::ctrl_t ctrl;
  hts_pkg::stat_t stat;

  hts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  hts_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .time_ms_i, .button_pressed_i, .recording_busy_i, .battery_test_busy_i,
    .restart_request_i,
    .led_write_o, .led_level_o, .haptic_code_o, .ship_request_o, .hold_committed_o
  );

  a_lvl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !led_write_o |-> led_level_o == 8'd0) else $error("level without write");
  a_ship_buzz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ship_request_o |-> haptic_code_o == hts_pkg::HAP_BUZZ)
    else $error("ship without buzz");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while result pending");

endmodule
